// ===== sv/dct_aan_pkg.sv =====
`timescale 1ns / 1ps

package dct_aan_pkg;

   localparam int SAMPLE_BITS_DEF    = 12;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int NUM_PTS            = 8;
   localparam int OUT_BITS           = 14;
   localparam int OUT_MAX            = 8191;
   localparam int OUT_MIN_MAG        = 8192;
   localparam int SCALE_STAGES       = 3;

   // rotation constants a1 a2 a4 a5, then output scales s0..s7, in q2.30
   localparam int IDX_A1 = 0;
   localparam int IDX_A2 = 1;
   localparam int IDX_A4 = 2;
   localparam int IDX_A5 = 3;
   localparam int IDX_S0 = 4;

   localparam logic [31:0] K_Q30 [12] = '{
      32'd759250125,  32'd581104888,  32'd1402911301, 32'd410903207,
      32'd379625062,  32'd273694418,  32'd290552444,  32'd322844578,
      32'd379625062,  32'd483171056,  32'd701455651,  32'd1375954754
   };

   function automatic logic [31:0] coef_q(input int idx, input int frac_bits);
      logic [31:0] k;
      int          sh;
      k  = K_Q30[idx];
      sh = 30 - frac_bits;
      return (k + (32'd1 << (sh - 1))) >> sh;
   endfunction

endpackage

// ===== sv/dct_aan_scale.sv =====
`timescale 1ns / 1ps

module dct_aan_scale #(
   parameter int COEF_FRAC_BITS = dct_aan_pkg::COEF_FRAC_BITS_DEF,
   parameter int Y_BITS         = dct_aan_pkg::SAMPLE_BITS_DEF
                                  + dct_aan_pkg::COEF_FRAC_BITS_DEF + 4,
   parameter int COEF_IDX       = dct_aan_pkg::IDX_S0
) (
   input  logic                                         clock,
   input  logic signed [Y_BITS-1:0]                     y,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0]      coef
);

   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = Y_BITS + CW;
   localparam int SH = 2 * COEF_FRAC_BITS;
   localparam int OB = dct_aan_pkg::OUT_BITS;
   localparam logic signed [CW-1:0] SCALE =
      CW'(dct_aan_pkg::coef_q(COEF_IDX, COEF_FRAC_BITS));
   localparam logic [PW-1:0] HALF = PW'(1) << (SH - 1);

   logic signed [PW-1:0] prod_ff;
   logic [PW-1:0]        mag_ff;
   logic                 neg_ff;
   logic [PW-1:0]        rnd;
   logic signed [OB-1:0] coef_in;
   logic signed [OB-1:0] coef_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PW'(y) * PW'(SCALE);
      neg_ff  <= prod_ff[PW-1];
      mag_ff  <= prod_ff[PW-1] ? $unsigned(-prod_ff) : $unsigned(prod_ff);
      coef_ff <= coef_in;
   end

   // round half away from zero on the magnitude, then saturate
   always_comb begin
      rnd = (mag_ff + HALF) >> SH;
      if (!neg_ff) begin
         coef_in = (rnd > PW'(dct_aan_pkg::OUT_MAX)) ? OB'(dct_aan_pkg::OUT_MAX)
                                                     : rnd[OB-1:0];
      end else begin
         coef_in = (rnd > PW'(dct_aan_pkg::OUT_MIN_MAG))
                   ? OB'(dct_aan_pkg::OUT_MIN_MAG)
                   : OB'(-rnd[OB-1:0]);
      end
   end

   assign coef = coef_ff;

endmodule

// ===== sv/dct_8point_aan_unit.sv =====
`timescale 1ns / 1ps

// channel   ports                               handshake
// ------------------------------------------------------------------------------
// request   req_sample_0 .. req_sample_7        taken when start is high, busy low
// response  rsp_coef_0 .. rsp_coef_7            one-cycle strobe rsp_valid
//
// one row enters per cycle; each transaction passes through the stages below
// pipeline: input register, three butterfly stages, constant multipliers, two
// adder stages, then three stages of output scaling, rounding and saturation
// synchronous reset clears the valid pipeline; rows in flight are dropped
// busy stays low: nothing inside stalls and the receiver cannot stall

module dct_8point_aan_unit #(
   parameter int SAMPLE_BITS    = dct_aan_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = dct_aan_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_0,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_1,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_2,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_3,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_4,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_5,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_6,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_7,
   output logic                                    rsp_valid,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_0,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_1,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_2,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_3,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_4,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_5,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_6,
   output logic signed [dct_aan_pkg::OUT_BITS-1:0] rsp_coef_7
);

   localparam int SB  = SAMPLE_BITS;
   localparam int F   = COEF_FRAC_BITS;
   localparam int CW  = F + 2;
   localparam int YW  = SB + F + 4;
   localparam int NP  = dct_aan_pkg::NUM_PTS;
   localparam int OB  = dct_aan_pkg::OUT_BITS;
   localparam int LAT = 7 + dct_aan_pkg::SCALE_STAGES;

   localparam logic signed [CW-1:0] A1 = CW'(dct_aan_pkg::coef_q(dct_aan_pkg::IDX_A1, F));
   localparam logic signed [CW-1:0] A2 = CW'(dct_aan_pkg::coef_q(dct_aan_pkg::IDX_A2, F));
   localparam logic signed [CW-1:0] A4 = CW'(dct_aan_pkg::coef_q(dct_aan_pkg::IDX_A4, F));
   localparam logic signed [CW-1:0] A5 = CW'(dct_aan_pkg::coef_q(dct_aan_pkg::IDX_A5, F));

   logic [LAT-1:0] valid_ff;
   logic [LAT-1:0] valid_in;

   logic signed [SB-1:0]   x_ff [NP];
   logic signed [SB:0]     p_ff [NP];
   logic signed [SB+1:0]   q0_ff, q1_ff, q2_ff, q3_ff, q4_ff, q5_ff, q6_ff;
   logic signed [SB:0]     p7_q_ff;
   logic signed [SB+2:0]   r0_ff, r1_ff, r2_ff, rs_ff;
   logic signed [SB+1:0]   q3_r_ff, q4_r_ff, q5_r_ff, q6_r_ff;
   logic signed [SB:0]     p7_r_ff;
   logic signed [YW-1:0]   e0_ff, e1_ff, e3_ff, e7_ff;
   logic signed [YW-1:0]   m2_ff, m4_ff, m5_ff, m6_ff, mrot_ff;
   logic signed [YW-1:0]   e0_f_ff, e1_f_ff, e4_ff, e6_ff, f2_ff, f3_ff, f5_ff, f7_ff;
   logic signed [YW-1:0]   y_ff [NP];
   logic signed [OB-1:0]   coef [NP];

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= req_sample_0;
      x_ff[1] <= req_sample_1;
      x_ff[2] <= req_sample_2;
      x_ff[3] <= req_sample_3;
      x_ff[4] <= req_sample_4;
      x_ff[5] <= req_sample_5;
      x_ff[6] <= req_sample_6;
      x_ff[7] <= req_sample_7;

      // first butterfly
      p_ff[0] <= (SB+1)'(x_ff[0]) + (SB+1)'(x_ff[7]);
      p_ff[1] <= (SB+1)'(x_ff[1]) + (SB+1)'(x_ff[6]);
      p_ff[2] <= (SB+1)'(x_ff[2]) + (SB+1)'(x_ff[5]);
      p_ff[3] <= (SB+1)'(x_ff[3]) + (SB+1)'(x_ff[4]);
      p_ff[4] <= (SB+1)'(x_ff[3]) - (SB+1)'(x_ff[4]);
      p_ff[5] <= (SB+1)'(x_ff[2]) - (SB+1)'(x_ff[5]);
      p_ff[6] <= (SB+1)'(x_ff[1]) - (SB+1)'(x_ff[6]);
      p_ff[7] <= (SB+1)'(x_ff[0]) - (SB+1)'(x_ff[7]);

      // second butterfly
      q0_ff   <= (SB+2)'(p_ff[0]) + (SB+2)'(p_ff[3]);
      q1_ff   <= (SB+2)'(p_ff[1]) + (SB+2)'(p_ff[2]);
      q2_ff   <= (SB+2)'(p_ff[1]) - (SB+2)'(p_ff[2]);
      q3_ff   <= (SB+2)'(p_ff[0]) - (SB+2)'(p_ff[3]);
      q4_ff   <= -(SB+2)'(p_ff[4]) - (SB+2)'(p_ff[5]);
      q5_ff   <= (SB+2)'(p_ff[5]) + (SB+2)'(p_ff[6]);
      q6_ff   <= (SB+2)'(p_ff[6]) + (SB+2)'(p_ff[7]);
      p7_q_ff <= p_ff[7];

      // third butterfly
      r0_ff   <= (SB+3)'(q0_ff) + (SB+3)'(q1_ff);
      r1_ff   <= (SB+3)'(q0_ff) - (SB+3)'(q1_ff);
      r2_ff   <= (SB+3)'(q2_ff) + (SB+3)'(q3_ff);
      rs_ff   <= (SB+3)'(q4_ff) + (SB+3)'(q6_ff);
      q3_r_ff <= q3_ff;
      q4_r_ff <= q4_ff;
      q5_r_ff <= q5_ff;
      q6_r_ff <= q6_ff;
      p7_r_ff <= p7_q_ff;

      // rotation products
      e0_ff   <= YW'(r0_ff) <<< F;
      e1_ff   <= YW'(r1_ff) <<< F;
      e3_ff   <= YW'(q3_r_ff) <<< F;
      e7_ff   <= YW'(p7_r_ff) <<< F;
      m2_ff   <= YW'(r2_ff) * YW'(A1);
      m4_ff   <= -(YW'(q4_r_ff) * YW'(A2));
      m5_ff   <= YW'(q5_r_ff) * YW'(A1);
      m6_ff   <= YW'(q6_r_ff) * YW'(A4);
      mrot_ff <= YW'(rs_ff) * YW'(A5);

      e0_f_ff <= e0_ff;
      e1_f_ff <= e1_ff;
      e4_ff   <= m4_ff - mrot_ff;
      e6_ff   <= m6_ff - mrot_ff;
      f2_ff   <= m2_ff + e3_ff;
      f3_ff   <= e3_ff - m2_ff;
      f5_ff   <= m5_ff + e7_ff;
      f7_ff   <= e7_ff - m5_ff;

      y_ff[0] <= e0_f_ff;
      y_ff[4] <= e1_f_ff;
      y_ff[2] <= f2_ff;
      y_ff[6] <= f3_ff;
      y_ff[5] <= e4_ff + f7_ff;
      y_ff[1] <= f5_ff + e6_ff;
      y_ff[7] <= f5_ff - e6_ff;
      y_ff[3] <= f7_ff - e4_ff;
   end

   for (genvar k = 0; k < NP; k++) begin : g_scale
      dct_aan_scale #(
         .COEF_FRAC_BITS (F),
         .Y_BITS         (YW),
         .COEF_IDX       (dct_aan_pkg::IDX_S0 + k)
      ) u_scale (
         .clock (clock),
         .y     (y_ff[k]),
         .coef  (coef[k])
      );
   end

   assign rsp_valid  = valid_ff[LAT-1];
   assign rsp_coef_0 = coef[0];
   assign rsp_coef_1 = coef[1];
   assign rsp_coef_2 = coef[2];
   assign rsp_coef_3 = coef[3];
   assign rsp_coef_4 = coef[4];
   assign rsp_coef_5 = coef[5];
   assign rsp_coef_6 = coef[6];
   assign rsp_coef_7 = coef[7];

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("accepted transaction did not produce a response");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("response without a matching transaction");

   a_flat_row : assert property (@(posedge clock) disable iff (reset)
      (start && req_sample_1 == req_sample_0 && req_sample_2 == req_sample_0
       && req_sample_3 == req_sample_0 && req_sample_4 == req_sample_0
       && req_sample_5 == req_sample_0 && req_sample_6 == req_sample_0
       && req_sample_7 == req_sample_0)
      |-> ##LAT (rsp_coef_1 == '0 && rsp_coef_2 == '0 && rsp_coef_3 == '0
                 && rsp_coef_4 == '0 && rsp_coef_5 == '0 && rsp_coef_6 == '0
                 && rsp_coef_7 == '0))
      else $error("flat row produced nonzero ac coefficients");
`endif

endmodule

// ===== tb/tb_dct_8point_aan_unit.sv =====
`timescale 1ns / 1ps

module tb_dct_8point_aan_unit;

   localparam int SAMPLE_W    = dct_aan_pkg::SAMPLE_BITS_DEF;
   localparam int FRAC_W      = dct_aan_pkg::COEF_FRAC_BITS_DEF;
   localparam int COEF_W      = dct_aan_pkg::OUT_BITS;
   localparam int ROW_LEN     = dct_aan_pkg::NUM_PTS;
   localparam int NUM_RANDOM  = 1600;
   localparam int DRAIN_WAIT  = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int S_MAX       = (1 << (SAMPLE_W - 1)) - 1;
   localparam int S_MIN       = -(1 << (SAMPLE_W - 1));

   // a1 a2 a4 a5, then output scales s0..s7, q2.30
   localparam longint AAN_Q30 [12] = '{
      64'd759250125,  64'd581104888,  64'd1402911301, 64'd410903207,
      64'd379625062,  64'd273694418,  64'd290552444,  64'd322844578,
      64'd379625062,  64'd483171056,  64'd701455651,  64'd1375954754
   };
   localparam int K_A1 = 0;
   localparam int K_A2 = 1;
   localparam int K_A4 = 2;
   localparam int K_A5 = 3;
   localparam int K_S0 = 4;

   typedef logic [ROW_LEN-1:0][SAMPLE_W-1:0] sample_vec_type;
   typedef logic [ROW_LEN-1:0][COEF_W-1:0]   coef_vec_type;

   class coef_scoreboard_type;
      coef_vec_type expected_rows[$];
      int           errors;
      int           rows_checked;

      function new();
         errors       = 0;
         rows_checked = 0;
      endfunction

      function longint fixed_const(int idx);
         return (AAN_Q30[idx] + (64'sd1 <<< (29 - FRAC_W))) >>> (30 - FRAC_W);
      endfunction

      function logic [COEF_W-1:0] scale_round_sat(longint g, longint s);
         longint prod;
         longint half;
         longint r;
         longint hi;
         longint lo;
         prod = g * s;
         half = 64'sd1 <<< (2 * FRAC_W - 1);
         hi   = (64'sd1 <<< (COEF_W - 1)) - 1;
         lo   = -(64'sd1 <<< (COEF_W - 1));
         if (prod >= 0) begin
            r = (prod + half) >>> (2 * FRAC_W);
         end else begin
            r = -((-prod + half) >>> (2 * FRAC_W));
         end
         if (r > hi) r = hi;
         if (r < lo) r = lo;
         return r[COEF_W-1:0];
      endfunction

      // aan flow graph: butterflies, rotation, final butterflies, output scaling
      function coef_vec_type aan_dct_row(sample_vec_type s);
         longint       x [ROW_LEN];
         longint       y [ROW_LEN];
         longint       p0, p1, p2, p3, p4, p5, p6, p7;
         longint       q0, q1, q2, q3, q4, q5, q6;
         longint       r0, r1, r2, rot, unity;
         longint       e0, e1, e2, e3, e4, e5, e6, e7;
         longint       f2, f3, f5, f7;
         coef_vec_type coefs;
         unity = 64'sd1 <<< FRAC_W;
         for (int n = 0; n < ROW_LEN; n++) begin
            x[n] = longint'($signed(s[n]));
         end
         p0 = x[0] + x[7];
         p1 = x[1] + x[6];
         p2 = x[2] + x[5];
         p3 = x[3] + x[4];
         p4 = x[3] - x[4];
         p5 = x[2] - x[5];
         p6 = x[1] - x[6];
         p7 = x[0] - x[7];
         q0 = p0 + p3;
         q1 = p1 + p2;
         q2 = p1 - p2;
         q3 = p0 - p3;
         q4 = -p4 - p5;
         q5 = p5 + p6;
         q6 = p6 + p7;
         r0 = q0 + q1;
         r1 = q0 - q1;
         r2 = q2 + q3;
         rot = (q4 + q6) * fixed_const(K_A5);
         e0 = r0 * unity;
         e1 = r1 * unity;
         e2 = r2 * fixed_const(K_A1);
         e3 = q3 * unity;
         e4 = -q4 * fixed_const(K_A2) - rot;
         e5 = q5 * fixed_const(K_A1);
         e6 = q6 * fixed_const(K_A4) - rot;
         e7 = p7 * unity;
         f2 = e2 + e3;
         f3 = e3 - e2;
         f5 = e5 + e7;
         f7 = e7 - e5;
         y[0] = e0;
         y[4] = e1;
         y[2] = f2;
         y[6] = f3;
         y[5] = e4 + f7;
         y[1] = f5 + e6;
         y[7] = f5 - e6;
         y[3] = f7 - e4;
         for (int n = 0; n < ROW_LEN; n++) begin
            coefs[n] = scale_round_sat(y[n], fixed_const(K_S0 + n));
         end
         return coefs;
      endfunction

      function void note_row(sample_vec_type s);
         expected_rows.push_back(aan_dct_row(s));
      endfunction

      function void check_row(coef_vec_type got);
         coef_vec_type want;
         if (expected_rows.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, nothing pending", $time);
            return;
         end
         want = expected_rows.pop_front();
         for (int n = 0; n < ROW_LEN; n++) begin
            if (got[n] !== want[n]) begin
               errors++;
               $display("%0t: row %0d coef_%0d expected %0d actual %0d", $time,
                        rows_checked, n, $signed(want[n]), $signed(got[n]));
            end
         end
         rows_checked++;
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction
   endclass

   logic           clock  = 1'b0;
   logic           reset  = 1'b1;
   logic           start  = 1'b0;
   sample_vec_type row_in = '0;
   logic           busy;
   logic           rsp_valid;
   logic signed [COEF_W-1:0] rsp_coef_0, rsp_coef_1, rsp_coef_2, rsp_coef_3;
   logic signed [COEF_W-1:0] rsp_coef_4, rsp_coef_5, rsp_coef_6, rsp_coef_7;

   coef_scoreboard_type board;
   int                  cycles = 0;

   dct_8point_aan_unit uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_sample_0 (row_in[0]),
      .req_sample_1 (row_in[1]),
      .req_sample_2 (row_in[2]),
      .req_sample_3 (row_in[3]),
      .req_sample_4 (row_in[4]),
      .req_sample_5 (row_in[5]),
      .req_sample_6 (row_in[6]),
      .req_sample_7 (row_in[7]),
      .rsp_valid    (rsp_valid),
      .rsp_coef_0   (rsp_coef_0),
      .rsp_coef_1   (rsp_coef_1),
      .rsp_coef_2   (rsp_coef_2),
      .rsp_coef_3   (rsp_coef_3),
      .rsp_coef_4   (rsp_coef_4),
      .rsp_coef_5   (rsp_coef_5),
      .rsp_coef_6   (rsp_coef_6),
      .rsp_coef_7   (rsp_coef_7)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d rows pending", $time, board.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_row(row_in);
         end
         if ($isunknown(rsp_valid)) begin
            board.errors++;
            $display("%0t: rsp_valid unknown", $time);
         end else if (rsp_valid) begin
            board.check_row({rsp_coef_7, rsp_coef_6, rsp_coef_5, rsp_coef_4,
                             rsp_coef_3, rsp_coef_2, rsp_coef_1, rsp_coef_0});
         end
      end
   end

   function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
      if (v > S_MAX) v = S_MAX;
      if (v < S_MIN) v = S_MIN;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic sample_vec_type directed_row(int k);
      sample_vec_type r;
      // sign pattern of the frequency 3 basis
      logic [ROW_LEN-1:0] f3_pos = 8'b0111_0001;
      r = '0;
      case (k)
         0: r = '0;
         1: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(S_MAX);
         2: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(S_MIN);
         3: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(n % 2 ? S_MIN : S_MAX);
         4: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(n % 2 ? S_MAX : S_MIN);
         13: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(n < 4 ? S_MAX : S_MIN);
         14: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(n < 4 ? S_MIN : S_MAX);
         15: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(S_MIN + 585 * n);
         16: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(f3_pos[n] ? S_MAX : S_MIN);
         17: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(n % 2 ? -1 : 1);
         18: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(-1);
         19: for (int n = 0; n < ROW_LEN; n++) r[n] = clamp_sample(1);
         20: for (int n = 0; n < ROW_LEN; n++) r[n] = n % 2 ? 12'haaa : 12'h555;
         21: for (int n = 0; n < ROW_LEN; n++) r[n] = n % 2 ? 12'h555 : 12'haaa;
         22: r[0] = clamp_sample(S_MIN);
         default: r[k-5] = clamp_sample(S_MAX);
      endcase
      return r;
   endfunction

   function automatic sample_vec_type random_row();
      sample_vec_type r;
      int             mode;
      int             base;
      mode = $urandom_range(0, 9);
      base = $urandom_range(0, 4095) - 2048;
      for (int n = 0; n < ROW_LEN; n++) begin
         case (mode)
            4, 5: r[n] = clamp_sample(base + $urandom_range(0, 128) - 64);
            6: r[n] = clamp_sample($urandom_range(0, 16) - 8);
            7: r[n] = clamp_sample($urandom_range(0, 1) ? S_MAX : S_MIN);
            8: r[n] = clamp_sample($urandom_range(0, 3) == 0 ? base : -base);
            9: r[n] = clamp_sample(base);
            default: r[n] = SAMPLE_W'($urandom_range(0, 4095));
         endcase
      end
      return r;
   endfunction

   task automatic send_row(sample_vec_type r);
      @(negedge clock);
      start  <= 1'b1;
      row_in <= r;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_cycles(int count);
      repeat (count) begin
         @(negedge clock);
         start  <= 1'b0;
         row_in <= random_row();
      end
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int burst;
      board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_cycles(2);

      for (int k = 0; k <= 22; k++) begin
         send_row(directed_row(k));
         if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
      end
      idle_cycles(1);
      wait_drained();

      sent = 0;
      while (sent < NUM_RANDOM) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < NUM_RANDOM; i++) begin
            send_row(random_row());
            sent++;
            if (sent % 500 == 0) begin
               idle_cycles(1);
               wait_drained();
            end
         end
         if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 8));
      end
      idle_cycles(1);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
